/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of this block.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define CBDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define CBDS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cbds_pkg.sv */
// Package for the brace depth scanner: character codes, word kinds, types.
// No dependencies.
`default_nettype none

package cbds_pkg;

  localparam int DEPTH_OUT_W = 16;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef logic signed [DEPTH_OUT_W-1:0] depth_out_t;

  // Lexer flags carried from one character to the next.
  typedef struct packed {
    logic comment_open;
    logic quote_double;
    logic line_found;
    logic line_stopped;
    logic string_open;
    logic escape_pending;
    logic slash_pending;
    logic star_pending;
  } scan_st_t;

  // One end-of-line result.
  typedef struct packed {
    logic       found;
    depth_out_t depth;
    logic       in_comment;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/cbds_if.sv */
// Valid/ready channel interfaces for the scanner's input and result words.
// Depends on cbds_pkg.
`default_nettype none

interface cbds_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;
  logic       force_block;

  modport source (output valid, kind, ch, force_block, input ready);
  modport sink   (input valid, kind, ch, force_block, output ready);
endinterface

interface cbds_out_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  cbds_pkg::depth_out_t     depth;
  logic                     in_comment;

  modport source (output valid, found, depth, in_comment, input ready);
  modport sink   (input valid, found, depth, in_comment, output ready);
endinterface

`default_nettype wire

/* rtl/core/c_brace_depth_scanner.sv */
// Top level of the brace depth scanner: lexer state registers, scan logic, result buffer.
// Depends on cbds_pkg, cbds_if, cbds_scan, cbds_outbuf.
//
//  channel   dir  handshake      word
//  in_chan   in   valid/ready    kind, ch[7:0], force_block
//  out_chan  out  valid/ready    found, depth[15:0] signed, in_comment
//
// One word accepted per cycle while in_chan.ready is high, character and end-of-line alike.
// An end-of-line word's result is on out_chan the cycle after acceptance,
// unless older results are still waiting on out_chan.ready ahead of it.
// in_chan.ready drops only when both result slots (output reg + skid) are full.
// Reset is synchronous, active low; clears depth, comment and line flags.
// Depth is DEPTH_BITS wide inside and saturates; out depth is its low 16 bits,
// sign extended when DEPTH_BITS is below 16.
`default_nettype none

module c_brace_depth_scanner #(
  parameter int DEPTH_BITS = 16
) (
  input wire   clk,
  input wire   rst_n,
  cbds_in_if.sink    in_chan,
  cbds_out_if.source out_chan
);
  import cbds_pkg::*;

  scan_st_t              flags_r, flags_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  res_t                  res_now;
  res_t                  res_out;
  logic                  buf_ready;
  logic                  accept;

  assign in_chan.ready = buf_ready;
  assign accept        = in_chan.valid && buf_ready;

  cbds_scan #(.DEPTH_BITS(DEPTH_BITS)) u_scan (
    .kind        (in_chan.kind),
    .ch          (in_chan.ch),
    .force_block (in_chan.force_block),
    .flags_i     (flags_r),
    .depth_i     (depth_r),
    .flags_o     (flags_nxt),
    .depth_o     (depth_nxt),
    .res_o       (res_now)
  );

  // Lexer state advances only on accepted words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      depth_r <= '0;
    end else if (accept) begin
      flags_r <= flags_nxt;
      depth_r <= depth_nxt;
    end
  end

  // End-of-line word snapshots the state from before its own clear.
  cbds_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && in_chan.kind == KIND_EOL),
    .push_data (res_now),
    .ready_o   (buf_ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (res_out)
  );

  assign out_chan.found      = res_out.found;
  assign out_chan.depth      = res_out.depth;
  assign out_chan.in_comment = res_out.in_comment;

endmodule

`default_nettype wire

/* rtl/core/cbds_scan.sv */
// Next-state logic for one word: comment/string/brace lexing, saturating depth.
// Depends on cbds_pkg.
`default_nettype none

module cbds_scan #(
  parameter int DEPTH_BITS = 16
) (
  input  wire                      kind,
  input  wire  [7:0]               ch,
  input  wire                      force_block,
  input  cbds_pkg::scan_st_t       flags_i,
  input  wire  [DEPTH_BITS-1:0]    depth_i,
  output cbds_pkg::scan_st_t       flags_o,
  output logic [DEPTH_BITS-1:0]    depth_o,
  output cbds_pkg::res_t           res_o
);
  import cbds_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEP_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic [DEPTH_BITS-1:0] DEP_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic [DEPTH_BITS-1:0] DEP_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  depth_out_t depth_ext;

  generate
    if (DEPTH_BITS >= DEPTH_OUT_W) begin : g_trunc
      assign depth_ext = depth_i[DEPTH_OUT_W-1:0];
    end else begin : g_sext
      assign depth_ext = {{(DEPTH_OUT_W-DEPTH_BITS){depth_i[DEPTH_BITS-1]}}, depth_i};
    end
  endgenerate

  assign res_o = '{found: flags_i.line_found, depth: depth_ext,
                   in_comment: flags_i.comment_open};

  always_comb begin
    logic done;
    logic [7:0] close_q;
    flags_o = flags_i;
    depth_o = depth_i;
    done    = 1'b0;
    close_q = flags_i.quote_double ? CH_DQUOTE : CH_SQUOTE;
    if (kind == KIND_EOL) begin
      flags_o.line_found     = 1'b0;
      flags_o.line_stopped   = 1'b0;
      flags_o.string_open    = 1'b0;
      flags_o.escape_pending = 1'b0;
      flags_o.slash_pending  = 1'b0;
      flags_o.star_pending   = 1'b0;
    end else if (!flags_i.line_stopped) begin
      if (flags_i.comment_open) begin
        // "/*" inside a comment is swallowed as a pair
        if (flags_i.slash_pending) begin
          flags_o.slash_pending = 1'b0;
          done = (ch == CH_STAR);
        end else if (flags_i.star_pending) begin
          flags_o.star_pending = 1'b0;
          if (ch == CH_SLASH) begin
            flags_o.comment_open = 1'b0;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (ch == CH_SLASH)     flags_o.slash_pending = 1'b1;
          else if (ch == CH_STAR) flags_o.star_pending  = 1'b1;
        end
      end else if (flags_i.string_open) begin
        if (flags_i.escape_pending)  flags_o.escape_pending = 1'b0;
        else if (ch == CH_BSLASH)    flags_o.escape_pending = 1'b1;
        else if (ch == close_q)      flags_o.string_open    = 1'b0;
      end else begin
        if (flags_i.slash_pending) begin
          flags_o.slash_pending = 1'b0;
          if (ch == CH_STAR) begin
            flags_o.comment_open = 1'b1;
            done = 1'b1;
          end else if (ch == CH_SLASH) begin
            flags_o.line_stopped = 1'b1;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (ch == CH_SLASH) begin
            flags_o.slash_pending = 1'b1;
          end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
            flags_o.string_open    = 1'b1;
            flags_o.quote_double   = (ch == CH_DQUOTE);
            flags_o.escape_pending = 1'b0;
          end else if (ch == CH_LBRACE) begin
            flags_o.line_found = 1'b1;
            if (depth_i != DEP_MAX) depth_o = depth_i + DEP_ONE;
          end else if (ch == CH_RBRACE) begin
            flags_o.line_found = 1'b1;
            if (depth_i != DEP_MIN) depth_o = depth_i - DEP_ONE;
          end else if (ch == CH_SEMI && depth_i == '0 && !force_block) begin
            flags_o.line_found   = 1'b1;
            flags_o.line_stopped = 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cbds_outbuf.sv */
// Two-entry result buffer (output register plus skid) for end-of-line words.
// Depends on cbds_pkg.
`default_nettype none

module cbds_outbuf (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  cbds_pkg::res_t  push_data,
  output logic            ready_o,
  output logic            out_valid,
  input  wire             out_ready,
  output cbds_pkg::res_t  out_data
);
  import cbds_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;

  assign ready_o   = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      if (skid_v_r) main_r <= skid_r;
      else if (push) main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cbds_checker.sv */
// Port-level checks for c_brace_depth_scanner, attached by bind.
// Depends on cbds_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cbds_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   in_kind,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire                   out_found,
  input cbds_pkg::depth_out_t  out_depth,
  input wire                   out_in_comment
);
  import cbds_pkg::*;

  `CBDS_ASSERT_RST(a_rst_no_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `CBDS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_depth) && $stable(out_in_comment), "stalled result changed")
  `CBDS_ASSERT(a_eol_emits, clk, rst_n, in_valid && in_ready && in_kind == KIND_EOL && !out_valid |=> out_valid, "end-of-line word gave no result")
  `CBDS_ASSERT(a_char_silent, clk, rst_n, in_valid && in_ready && in_kind == KIND_CHAR && !out_valid |=> !out_valid, "character word gave a result")

endmodule

bind c_brace_depth_scanner cbds_checker u_cbds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_kind        (in_chan.kind),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_found      (out_chan.found),
  .out_depth      (out_chan.depth),
  .out_in_comment (out_chan.in_comment)
);

`default_nettype wire

/* dv/c_brace_depth_scanner_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for c_brace_depth_scanner: directed lines, random text lines, depth swings.
// Depends on cbds_pkg, cbds_if and the scanner RTL.

module c_brace_depth_scanner_tb;
  import cbds_pkg::*;

  localparam int DEPTH_BITS      = 16;
  localparam int RANDOM_WORDS    = 1100;
  localparam int DEPTH_SWING     = 96;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 20000;

  // receiver stall styles
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  // token shapes for the random line builder
  typedef enum logic [3:0] {
    TOK_IDENT, TOK_BRACE, TOK_SEMI, TOK_BLOCK_CMT, TOK_LINE_CMT,
    TOK_STRING, TOK_RAW, TOK_SLASH, TOK_STAR, TOK_SPACE
  } tok_e;

  // Line-scanner predictor plus the queue of end-of-line results it expects.
  class depth_scoreboard;
    longint brace_depth;
    bit     comment_open, quote_double;
    bit     line_found, line_stopped, string_open;
    bit     escape_pending, slash_pending, star_pending;
    res_t   line_results_q[$];
    int     errors;

    function new();
      brace_depth  = 0;
      comment_open = 0;
      quote_double = 0;
      errors       = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_found     = 0;
      line_stopped   = 0;
      string_open    = 0;
      escape_pending = 0;
      slash_pending  = 0;
      star_pending   = 0;
    endfunction

    function void scan_char(logic [7:0] c, logic frc);
      longint lim;
      lim = longint'(1) << (DEPTH_BITS - 1);
      if (line_stopped) return;
      if (comment_open) begin
        if (slash_pending) begin
          slash_pending = 0;
          if (c == CH_STAR) return;   // nested opener eats its star
        end else if (star_pending) begin
          star_pending = 0;
          if (c == CH_SLASH) begin
            comment_open = 0;
            return;
          end
        end
        if (c == CH_SLASH) slash_pending = 1;
        else if (c == CH_STAR) star_pending = 1;
        return;
      end
      if (string_open) begin
        if (escape_pending) escape_pending = 0;
        else if (c == CH_BSLASH) escape_pending = 1;
        else if (c == (quote_double ? CH_DQUOTE : CH_SQUOTE)) string_open = 0;
        return;
      end
      if (slash_pending) begin
        slash_pending = 0;
        if (c == CH_STAR) begin
          comment_open = 1;
          return;
        end
        if (c == CH_SLASH) begin
          line_stopped = 1;
          return;
        end
      end
      if (c == CH_SLASH) begin
        slash_pending = 1;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        string_open    = 1;
        quote_double   = (c == CH_DQUOTE);
        escape_pending = 0;
      end else if (c == CH_LBRACE) begin
        line_found = 1;
        if (brace_depth < lim - 1) brace_depth++;
      end else if (c == CH_RBRACE) begin
        line_found = 1;
        if (brace_depth > -lim) brace_depth--;
      end else if (c == CH_SEMI && brace_depth == 0 && !frc) begin
        line_found   = 1;
        line_stopped = 1;
      end
    endfunction

    // called for every accepted input word
    function void note_word(logic kind, logic [7:0] c, logic frc);
      res_t r;
      if (kind == KIND_CHAR) begin
        scan_char(c, frc);
      end else begin
        r.found      = line_found;
        r.depth      = depth_out_t'(brace_depth);
        r.in_comment = comment_open;
        line_results_q.push_back(r);
        clear_line();
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic found, depth_out_t depth, logic in_comment);
      res_t want;
      if (line_results_q.size() == 0) begin
        report($sformatf("unexpected result found=%0b depth=%0d in_comment=%0b",
                         found, depth, in_comment));
        return;
      end
      want = line_results_q.pop_front();
      if (found !== want.found)
        report($sformatf("found got %0b want %0b", found, want.found));
      if (depth !== want.depth)
        report($sformatf("depth got %0d want %0d", depth, want.depth));
      if (in_comment !== want.in_comment)
        report($sformatf("in_comment got %0b want %0b", in_comment, want.in_comment));
    endtask

    function int pending();
      return line_results_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cbds_in_if  in_chan();
  cbds_out_if out_chan();

  depth_scoreboard sb;

  int sent_words;     // accepted input words so far
  int burst_left;     // words left in the current sender burst
  bit hold_off_req;   // stimulus asks the receiver for one long stall

  c_brace_depth_scanner #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result monitor: signals read right after the edge still hold the
  // values the DUT saw, so the handshake is judged without races.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.found, out_chan.depth, out_chan.in_comment);
  end

  // Receiver: stretches of free flow, coin-flip stalls, sparse ready and
  // mostly-ready, plus one long hold-off on request that backs the block up.
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    mode      = RX_FREE;
    mode_left = 0;
    out_chan.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(5, 80);
      end
      mode_left--;
      case (mode)
        RX_FREE:   out_chan.ready <= 1'b1;
        RX_COIN:   out_chan.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_chan.ready <= (mode_left % 4 == 0);
        default:   out_chan.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Offer one word and hold it until accepted. The sender runs in bursts;
  // between bursts valid drops for a random gap (sometimes none at all).
  task send_word(logic kind, logic [7:0] c, logic frc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_chan.valid       <= 1'b1;
    in_chan.kind        <= kind;
    in_chan.ch          <= c;
    in_chan.force_block <= frc;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_word(kind, c, frc);
    sent_words++;
  endtask

  task send_char(logic [7:0] c, logic frc);
    send_word(KIND_CHAR, c, frc);
  endtask

  // End of line: ch and force_block are don't-care, so randomize them.
  task send_eol();
    send_word(KIND_EOL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task send_text(string s, logic frc);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], frc);
    send_eol();
  endtask

  // Byte for comment and string bodies, heavy on the characters that matter.
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_BSLASH;
      3:       return ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
      4:       return ($urandom_range(0, 1) == 1) ? CH_LBRACE : CH_RBRACE;
      5:       return CH_SEMI;
      6:       return 8'($urandom_range(0, 255));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  // One random source line built from tokens, then end of line.
  // Braces lean back toward depth zero so terminating semicolons stay live.
  task gen_line();
    logic       line_frc;
    logic       frc;
    logic [7:0] q;
    tok_e       tok;
    int         ntok;
    line_frc = ($urandom_range(0, 3) == 0);
    ntok     = $urandom_range(0, 10);
    repeat (ntok) begin
      frc = line_frc ^ ($urandom_range(0, 9) == 0);
      tok = tok_e'($urandom_range(0, 11) % 10);
      case (tok)
        TOK_IDENT:
          repeat ($urandom_range(1, 4)) send_char(8'("a" + $urandom_range(0, 25)), frc);
        TOK_BRACE: begin
          if (sb.brace_depth > 0 && $urandom_range(0, 2) != 0)
            send_char(CH_RBRACE, frc);
          else if (sb.brace_depth < 0 && $urandom_range(0, 2) != 0)
            send_char(CH_LBRACE, frc);
          else
            send_char(($urandom_range(0, 1) == 1) ? CH_LBRACE : CH_RBRACE, frc);
        end
        TOK_SEMI:
          send_char(CH_SEMI, frc);
        TOK_BLOCK_CMT: begin
          send_char(CH_SLASH, frc);
          send_char(CH_STAR, frc);
          repeat ($urandom_range(0, 5)) send_char(body_byte(), frc);
          if ($urandom_range(0, 3) != 0) begin
            send_char(CH_STAR, frc);
            send_char(CH_SLASH, frc);
          end
        end
        TOK_LINE_CMT: begin
          send_char(CH_SLASH, frc);
          send_char(CH_SLASH, frc);
          repeat ($urandom_range(0, 5)) send_char(body_byte(), frc);
        end
        TOK_STRING: begin
          q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
          send_char(q, frc);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) begin
              send_char(CH_BSLASH, frc);
              send_char(($urandom_range(0, 1) == 1) ? q : body_byte(), frc);
            end else begin
              send_char(body_byte(), frc);
            end
          end
          if ($urandom_range(0, 4) != 0) send_char(q, frc);
        end
        TOK_RAW:   send_char(8'($urandom_range(0, 255)), frc);
        TOK_SLASH: send_char(CH_SLASH, frc);
        TOK_STAR:  send_char(CH_STAR, frc);
        default:   send_char(8'h20, frc);
      endcase
    end
    send_eol();
  endtask

  // Swing the depth well above zero, well below it and back to zero,
  // with a line break now and then so intermediate depths are checked.
  task run_depth_swing();
    int i;
    for (i = 0; i < DEPTH_SWING; i++) begin
      send_char(CH_LBRACE, 1'($urandom_range(0, 1)));
      if (i % 16 == 15) send_eol();
    end
    send_eol();
    for (i = 0; i < 2 * DEPTH_SWING; i++) begin
      send_char(CH_RBRACE, 1'($urandom_range(0, 1)));
      if (i % 16 == 15) send_eol();
    end
    send_eol();
    for (i = 0; i < DEPTH_SWING; i++) begin
      send_char(CH_LBRACE, 1'($urandom_range(0, 1)));
      if (i % 16 == 15) send_eol();
    end
    send_eol();
  endtask

  initial begin : stimulus
    int drain;
    int start_words;
    sb           = new();
    sent_words   = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.kind        <= KIND_CHAR;
    in_chan.ch          <= 8'h00;
    in_chan.force_block <= 1'b0;
    rst_n               <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines.
    send_text(";{", 1'b0);           // semicolon at depth zero stops the line
    send_text("/{/", 1'b0);          // lone slashes, one at end of line
    send_text("/*/*/", 1'b0);        // opener inside a comment, comment stays open
    send_text("*/\"\\\"}", 1'b0);    // close comment, escaped quote, string left open
    send_char(CH_RBRACE, 1'b0);
    send_char(CH_SEMI, 1'b1);        // forced: the semicolon does not stop
    send_char(8'h00, 1'b0);          // byte zero is ordinary
    send_char(8'hFF, 1'b1);
    send_eol();

    run_depth_swing();

    // Random lines; the receiver takes its long hold-off early on while
    // the sender keeps pushing, so the result buffer fills and stalls input.
    hold_off_req = 1'b1;
    start_words  = sent_words;
    while (sent_words - start_words < RANDOM_WORDS)
      gen_line();
    in_chan.valid <= 1'b0;

    drain = 0;
    while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (10) @(posedge clk);

    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
